>>> hw/rtl/nearest_centre_assign_defines.svh
// Assertion macros shared by the RTL. Clock and reset are the module's own
// clock and reset signals.
`ifndef NEAREST_CENTRE_ASSIGN_DEFINES_SVH
`define NEAREST_CENTRE_ASSIGN_DEFINES_SVH

// Same-cycle implication.
`define NCA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define NCA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/nca_pkg.sv
package nca_pkg;

   localparam int MAX_CENTRES = 16;
   localparam int MAX_DIMS    = 16;

   localparam int CIDX_W  = $clog2(MAX_CENTRES);
   localparam int DIDX_W  = $clog2(MAX_DIMS);
   localparam int ADDR_W  = CIDX_W + DIDX_W;
   localparam int COORD_W = 16;
   localparam int WGT_W   = 16;
   localparam int DIST_W  = 36;
   localparam int COST_W  = 64;
   localparam int CSR_W   = 5;

   // squares are below 2**32, MAX_DIMS of them summed
   localparam int SQ_W    = 2 * COORD_W;
   localparam int SUM_W   = SQ_W + DIDX_W;
   localparam int ACC_W   = (SUM_W > DIST_W) ? SUM_W : DIST_W + 1;

   // shared multiplier operands
   localparam int MUL_A_W = DIST_W;
   localparam int MUL_B_W = WGT_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // pipeline depth from last issue to final compare result
   localparam int DRAIN_CYCLES = 3;
   localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

   // input item modes
   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_POINT = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   // register indexes
   localparam logic CSR_ACTIVE_CENTRES = 1'b0;
   localparam logic CSR_ACTIVE_DIMS    = 1'b1;

   typedef struct packed {
      logic [1:0]                mode;
      logic [3:0]                centre_index;
      logic [3:0]                dim_index;
      logic signed [COORD_W-1:0] coord_value;
      logic [WGT_W-1:0]          point_weight;
      logic                      last_coord;
   } req_type;

   typedef struct packed {
      logic [3:0]        nearest_index;
      logic [DIST_W-1:0] nearest_distance;
      logic [COST_W-1:0] total_cost;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_TERM,
      ST_COST
   } seq_state_type;

   // sequencer to datapath control
   typedef struct packed {
      logic              issue;
      logic              first;
      logic              last;
      logic [CIDX_W-1:0] centre;
      logic [DIDX_W-1:0] dim;
      logic              term_sel;
      logic              cost_en;
   } seq_ctl_type;

   // tag carried along the distance pipeline
   typedef struct packed {
      logic              valid;
      logic              first;
      logic              last;
      logic [CIDX_W-1:0] centre;
   } tag_type;

   // register value to last index: zero acts as one, large values saturate
   function automatic int count_to_last(int v, int maxv);
      int r;
      if (v == 0)
         r = 0;
      else if (v > maxv)
         r = maxv - 1;
      else
         r = v - 1;
      return r;
   endfunction

endpackage

>>> hw/rtl/nearest_centre_assign.sv
// Nearest-centre assignment with weighted running cost. Centre coordinates
// (mode load) go into a 16x16 table; point coordinates (mode point) go into a
// small point register file; mode clear zeroes the cost. Load, clear and
// non-final point transfers leave busy low. A point coordinate marked last
// starts a scan: busy rises the next cycle and stays high through the scan,
// drain, term and cost states; no transfer is accepted while busy is high.
// The scan is paced by one shared multiplier and one centre-table read port,
// handling one coordinate difference per cycle. The result shows on rsp_data
// with rsp_valid for exactly one cycle, in the first cycle busy is low again;
// the receiver cannot stall, so it must take it then. The user must write
// registers through csr_we/csr_index/csr_wdata only while no scan runs; the
// block itself does not enforce this. Centre entries read before they were
// loaded give undefined results.
`include "nearest_centre_assign_defines.svh"

module nearest_centre_assign (
   input  logic                      clock,
   input  logic                      reset,
   // input item
   input  logic                      start,
   output logic                      busy,
   input  nca_pkg::req_type          req_data,
   // result
   output logic                      rsp_valid,
   output nca_pkg::rsp_type          rsp_data,
   // register writes
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [nca_pkg::CSR_W-1:0] csr_wdata
);

   // ------------------------------------------------------------------
   // Transfer decode
   // ------------------------------------------------------------------
   logic accept;
   logic do_load, do_point, do_clear, go;

   assign accept = start && !busy;

   always_comb begin
      do_load  = 1'b0;
      do_point = 1'b0;
      do_clear = 1'b0;
      unique case (req_data.mode)
         nca_pkg::MODE_LOAD:  do_load  = accept;
         nca_pkg::MODE_POINT: do_point = accept;
         nca_pkg::MODE_CLEAR: do_clear = accept;
         default: ;  // unused mode: dropped
      endcase
   end

   assign go = do_point && req_data.last_coord;

   // ------------------------------------------------------------------
   // Active counts, held as last index (0 means one, large saturates)
   // ------------------------------------------------------------------
   logic [nca_pkg::CIDX_W-1:0] c_last_ff, c_last_in;
   logic [nca_pkg::DIDX_W-1:0] d_last_ff, d_last_in;

   always_comb begin
      c_last_in = c_last_ff;
      d_last_in = d_last_ff;
      if (csr_we) begin
         unique case (csr_index)
            nca_pkg::CSR_ACTIVE_CENTRES:
               c_last_in = nca_pkg::CIDX_W'(nca_pkg::count_to_last(int'(csr_wdata),
                                                                  nca_pkg::MAX_CENTRES));
            nca_pkg::CSR_ACTIVE_DIMS:
               d_last_in = nca_pkg::DIDX_W'(nca_pkg::count_to_last(int'(csr_wdata),
                                                                  nca_pkg::MAX_DIMS));
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_last_ff <= '0;
         d_last_ff <= '0;
      end else begin
         c_last_ff <= c_last_in;
         d_last_ff <= d_last_in;
      end
   end

   // ------------------------------------------------------------------
   // Point coordinates: written on point transfers, read by the scan
   // ------------------------------------------------------------------
   logic signed [nca_pkg::COORD_W-1:0] point_ff [nca_pkg::MAX_DIMS];
   logic                               point_wr;
   logic [nca_pkg::WGT_W-1:0]          weight_ff;

   assign point_wr = do_point && (int'(req_data.dim_index) < nca_pkg::MAX_DIMS);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < nca_pkg::MAX_DIMS; i++) begin
            point_ff[i] <= '0;
         end
      end else if (point_wr) begin
         point_ff[req_data.dim_index[nca_pkg::DIDX_W-1:0]] <= req_data.coord_value;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         weight_ff <= req_data.point_weight;
      end
   end

   // ------------------------------------------------------------------
   // Centre table
   // ------------------------------------------------------------------
   logic                               load_wr;
   logic [nca_pkg::ADDR_W-1:0]         rd_addr;
   logic signed [nca_pkg::COORD_W-1:0] centre_value;
   nca_pkg::seq_ctl_type               ctl;

   assign load_wr = do_load
                 && (int'(req_data.centre_index) < nca_pkg::MAX_CENTRES)
                 && (int'(req_data.dim_index) < nca_pkg::MAX_DIMS);

   nca_centre_ram u_ram (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr ({req_data.centre_index[nca_pkg::CIDX_W-1:0],
                 req_data.dim_index[nca_pkg::DIDX_W-1:0]}),
      .wr_data (req_data.coord_value),
      .rd_en   (ctl.issue),
      .rd_addr (rd_addr),
      .rd_data (centre_value)
   );

   // ------------------------------------------------------------------
   // Sequencer and distance datapath
   // ------------------------------------------------------------------
   logic [nca_pkg::CIDX_W-1:0] best_index;
   logic [nca_pkg::DIST_W-1:0] best_shown;
   logic [nca_pkg::PROD_W-1:0] prod;

   nca_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .go      (go),
      .c_last  (c_last_ff),
      .d_last  (d_last_ff),
      .ctl     (ctl),
      .rd_addr (rd_addr),
      .busy    (busy)
   );

   nca_dist u_dist (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .centre_value (centre_value),
      .point_value  (point_ff[ctl.dim]),
      .weight       (weight_ff),
      .best_index   (best_index),
      .best_shown   (best_shown),
      .prod         (prod)
   );

   // ------------------------------------------------------------------
   // Running cost: saturating add of distance times weight
   // ------------------------------------------------------------------
   logic [nca_pkg::COST_W-1:0] cost_ff, cost_in;
   logic [nca_pkg::COST_W:0]   cost_sum;

   always_comb begin
      cost_sum = {1'b0, cost_ff} + (nca_pkg::COST_W+1)'(prod);
      cost_in  = cost_ff;
      if (do_clear) begin
         cost_in = '0;
      end else if (ctl.cost_en) begin
         cost_in = cost_sum[nca_pkg::COST_W] ? '1 : cost_sum[nca_pkg::COST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cost_ff <= '0;
      end else begin
         cost_ff <= cost_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register: one-cycle strobe
   // ------------------------------------------------------------------
   logic             rsp_valid_ff;
   nca_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.cost_en;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.cost_en) begin
         rsp_data_ff.nearest_index    <= 4'(best_index);
         rsp_data_ff.nearest_distance <= best_shown;
         rsp_data_ff.total_cost       <= cost_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `NCA_ASSERT_NEXT(a_last_coord_starts_scan, go, busy, "final point coordinate did not start a scan")
   `NCA_ASSERT_NEXT(a_rsp_single_cycle, rsp_valid, !rsp_valid, "result strobe longer than one cycle")
   `NCA_ASSERT_NOW(a_rsp_after_scan, rsp_valid, $past(busy) && !busy, "result without a finished scan")
   `NCA_ASSERT_NOW(a_rsp_index_active, rsp_valid, rsp_data.nearest_index <= 4'(c_last_ff), "nearest index beyond active centres")

endmodule

>>> hw/rtl/nca_centre_ram.sv
module nca_centre_ram (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [nca_pkg::ADDR_W-1:0]         wr_addr,
   input  logic signed [nca_pkg::COORD_W-1:0] wr_data,
   input  logic                               rd_en,
   input  logic [nca_pkg::ADDR_W-1:0]         rd_addr,
   output logic signed [nca_pkg::COORD_W-1:0] rd_data
);

   logic signed [nca_pkg::COORD_W-1:0] mem [2**nca_pkg::ADDR_W];
   logic signed [nca_pkg::COORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/nca_mul.sv
module nca_mul (
   input  logic                               clock,
   input  logic [nca_pkg::MUL_A_W-1:0]        op_a,
   input  logic [nca_pkg::MUL_B_W-1:0]        op_b,
   output logic [nca_pkg::PROD_W-1:0]         prod
);

   logic [nca_pkg::PROD_W-1:0] prod_ff;
   logic [nca_pkg::PROD_W-1:0] prod_in;

   assign prod_in = nca_pkg::PROD_W'(op_a) * nca_pkg::PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> hw/rtl/nca_dist.sv
module nca_dist (
   input  logic                               clock,
   input  logic                               reset,
   input  nca_pkg::seq_ctl_type               ctl,
   input  logic signed [nca_pkg::COORD_W-1:0] centre_value,
   input  logic signed [nca_pkg::COORD_W-1:0] point_value,
   input  logic [nca_pkg::WGT_W-1:0]          weight,
   output logic [nca_pkg::CIDX_W-1:0]         best_index,
   output logic [nca_pkg::DIST_W-1:0]         best_shown,
   output logic [nca_pkg::PROD_W-1:0]         prod
);

   nca_pkg::tag_type s1_tag_ff, s2_tag_ff, s3_tag_ff;
   logic signed [nca_pkg::COORD_W-1:0] s1_point_ff;
   logic [nca_pkg::COORD_W-1:0]        s2_abs_ff;
   logic [nca_pkg::COORD_W-1:0]        s2_abs_in;
   logic signed [nca_pkg::COORD_W:0]   diff;
   logic [nca_pkg::COORD_W:0]          mag;

   logic [nca_pkg::ACC_W-1:0]  sum_ff, sum_in;
   logic [nca_pkg::ACC_W-1:0]  best_ff;
   logic [nca_pkg::CIDX_W-1:0] best_idx_ff;
   logic [nca_pkg::ACC_W-1:0]  square;
   logic                       take;

   logic [nca_pkg::MUL_A_W-1:0] op_a;
   logic [nca_pkg::MUL_B_W-1:0] op_b;

   // stage 1: point value beside the registered RAM read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
      end else begin
         s1_tag_ff.valid  <= ctl.issue;
         s1_tag_ff.first  <= ctl.first;
         s1_tag_ff.last   <= ctl.last;
         s1_tag_ff.centre <= ctl.centre;
      end
   end

   always_ff @(posedge clock) begin
      s1_point_ff <= point_value;
   end

   // stage 2: magnitude of the difference, exact in 16 bits
   always_comb begin
      diff      = {s1_point_ff[nca_pkg::COORD_W-1], s1_point_ff}
                - {centre_value[nca_pkg::COORD_W-1], centre_value};
      mag       = diff[nca_pkg::COORD_W] ? (nca_pkg::COORD_W+1)'(-diff)
                                         : (nca_pkg::COORD_W+1)'(diff);
      s2_abs_in = mag[nca_pkg::COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_tag_ff <= '0;
         s3_tag_ff <= '0;
      end else begin
         s2_tag_ff <= s1_tag_ff;
         s3_tag_ff <= s2_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_abs_ff <= s2_abs_in;
   end

   // one multiplier: squares while scanning, distance times weight after
   always_comb begin
      if (ctl.term_sel) begin
         op_a = best_shown;
         op_b = weight;
      end else begin
         op_a = nca_pkg::MUL_A_W'(s2_abs_ff);
         op_b = nca_pkg::MUL_B_W'(s2_abs_ff);
      end
   end

   nca_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // stage 3: accumulate, strict compare keeps the lowest index on ties
   always_comb begin
      square = nca_pkg::ACC_W'(prod[nca_pkg::SQ_W-1:0]);
      sum_in = s3_tag_ff.first ? square : sum_ff + square;
      take   = s3_tag_ff.valid && s3_tag_ff.last
             && ((s3_tag_ff.centre == '0) || (sum_in < best_ff));
   end

   always_ff @(posedge clock) begin
      if (s3_tag_ff.valid) begin
         sum_ff <= sum_in;
      end
      if (take) begin
         best_ff     <= sum_in;
         best_idx_ff <= s3_tag_ff.centre;
      end
   end

   assign best_index = best_idx_ff;
   assign best_shown = (best_ff > nca_pkg::ACC_W'(nca_pkg::DIST_MAX))
                     ? nca_pkg::DIST_MAX : best_ff[nca_pkg::DIST_W-1:0];

endmodule

>>> hw/rtl/nca_seq.sv
`include "nearest_centre_assign_defines.svh"

module nca_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  logic [nca_pkg::CIDX_W-1:0] c_last,
   input  logic [nca_pkg::DIDX_W-1:0] d_last,
   output nca_pkg::seq_ctl_type       ctl,
   output logic [nca_pkg::ADDR_W-1:0] rd_addr,
   output logic                       busy
);

   nca_pkg::seq_state_type state_ff, state_in;
   logic [nca_pkg::CIDX_W-1:0]  c_ff, c_in;
   logic [nca_pkg::DIDX_W-1:0]  d_ff, d_in;
   logic [nca_pkg::DRAIN_W-1:0] drain_ff, drain_in;
   logic                        scan_done, drain_done;

   assign scan_done  = (c_ff == c_last) && (d_ff == d_last);
   assign drain_done = (drain_ff == nca_pkg::DRAIN_W'(nca_pkg::DRAIN_CYCLES - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nca_pkg::ST_IDLE: begin
            if (go) state_in = nca_pkg::ST_SCAN;
         end
         nca_pkg::ST_SCAN: begin
            if (scan_done) state_in = nca_pkg::ST_DRAIN;
         end
         nca_pkg::ST_DRAIN: begin
            if (drain_done) state_in = nca_pkg::ST_TERM;
         end
         nca_pkg::ST_TERM: state_in = nca_pkg::ST_COST;
         nca_pkg::ST_COST: state_in = nca_pkg::ST_IDLE;
         default:          state_in = nca_pkg::ST_IDLE;
      endcase
   end

   // counters: dim fastest, then centre
   always_comb begin
      c_in     = c_ff;
      d_in     = d_ff;
      drain_in = '0;
      unique case (state_ff)
         nca_pkg::ST_IDLE: begin
            c_in = '0;
            d_in = '0;
         end
         nca_pkg::ST_SCAN: begin
            if (d_ff == d_last) begin
               d_in = '0;
               c_in = c_ff + 1'b1;
            end else begin
               d_in = d_ff + 1'b1;
            end
         end
         nca_pkg::ST_DRAIN: drain_in = drain_ff + 1'b1;
         default:           drain_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nca_pkg::ST_IDLE;
         c_ff     <= '0;
         d_ff     <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         c_ff     <= c_in;
         d_ff     <= d_in;
         drain_ff <= drain_in;
      end
   end

   // outputs
   always_comb begin
      ctl.issue    = (state_ff == nca_pkg::ST_SCAN);
      ctl.first    = (d_ff == '0);
      ctl.last     = (d_ff == d_last);
      ctl.centre   = c_ff;
      ctl.dim      = d_ff;
      ctl.term_sel = (state_ff == nca_pkg::ST_TERM);
      ctl.cost_en  = (state_ff == nca_pkg::ST_COST);
      rd_addr      = {c_ff, d_ff};
      busy         = (state_ff != nca_pkg::ST_IDLE);
   end

   `NCA_ASSERT_NOW(a_scan_in_range, state_ff == nca_pkg::ST_SCAN, (c_ff <= c_last) && (d_ff <= d_last), "scan counter beyond active range")
   `NCA_ASSERT_NEXT(a_scan_ends_in_drain, (state_ff == nca_pkg::ST_SCAN) && scan_done, (state_ff == nca_pkg::ST_DRAIN) && (drain_ff == '0), "scan did not hand over to drain")

endmodule
